FILE: hw/rtl/ialu_pkg.sv
package ialu_pkg;

    localparam int DataW  = 32;
    localparam int OpW    = 4;
    localparam int ShiftW = 5;
    localparam int Digits = 10;

    // Opcodes
    localparam logic [OpW-1:0] OP_ADD   = 4'd0;
    localparam logic [OpW-1:0] OP_SUB   = 4'd1;
    localparam logic [OpW-1:0] OP_MUL   = 4'd2;
    localparam logic [OpW-1:0] OP_DIV   = 4'd3;
    localparam logic [OpW-1:0] OP_MOD   = 4'd4;
    localparam logic [OpW-1:0] OP_AND   = 4'd5;
    localparam logic [OpW-1:0] OP_OR    = 4'd6;
    localparam logic [OpW-1:0] OP_XOR   = 4'd7;
    localparam logic [OpW-1:0] OP_NOT   = 4'd8;
    localparam logic [OpW-1:0] OP_NEG   = 4'd9;
    localparam logic [OpW-1:0] OP_NINES = 4'd10;
    localparam logic [OpW-1:0] OP_TENS  = 4'd11;
    localparam logic [OpW-1:0] OP_SHL   = 4'd12;
    localparam logic [OpW-1:0] OP_SHR   = 4'd13;

    // Powers of ten, 10^0 .. 10^10
    localparam logic [63:0] POW10 [0:Digits] = '{
        64'd1, 64'd10, 64'd100, 64'd1000, 64'd10000, 64'd100000,
        64'd1000000, 64'd10000000, 64'd100000000, 64'd1000000000,
        64'd10000000000
    };

    // Side data that travels alongside the divider
    typedef struct packed {
        logic [OpW-1:0]   op;
        logic [DataW-1:0] res;
        logic             neg_q;
        logic             neg_r;
        logic             dz;
    } ialu_side_t;

    // Divider working set
    typedef struct packed {
        logic [DataW-1:0] rem;
        logic [DataW-1:0] dvd;
        logic [DataW-1:0] dvs;
    } ialu_div_t;

    // All-nines value with as many digits as a, modulo 2^32; zero when a <= 0
    function automatic logic [DataW-1:0] nines_base(input logic [DataW-1:0] a);
        logic [DataW-1:0] base;
        base = '0;
        if (!a[DataW-1] && (a != '0))
        begin
            for (int k = 1; k <= Digits; k++)
            begin
                if (a >= POW10[k-1][DataW-1:0])
                begin
                    base = POW10[k][DataW-1:0] - 32'd1;
                end
            end
        end
        return base;
    endfunction

endpackage

FILE: hw/rtl/ialu_front.sv
module ialu_front
    import ialu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [OpW-1:0]    op,
    input  logic [DataW-1:0]  a,
    input  logic [DataW-1:0]  b,
    input  logic [ShiftW-1:0] sh,
    output logic              valid_reg,
    output ialu_side_t        side_reg,
    output ialu_div_t         div_reg
);

    ialu_side_t       side_next;
    ialu_div_t        div_next;
    logic [DataW-1:0] prod;
    logic [DataW-1:0] nines;

    // Decode the non-divide operations and set up the divider
    always_comb
    begin
        prod  = a * b;
        nines = nines_base(a) - a;
        if (a[DataW-1] || (a == '0))
        begin
            nines = '0;
        end
        side_next.op    = op;
        side_next.neg_q = a[DataW-1] ^ b[DataW-1];
        side_next.neg_r = a[DataW-1];
        side_next.dz    = ((op == OP_DIV) || (op == OP_MOD)) && (b == '0);
        unique case (op)
            OP_ADD:   side_next.res = a + b;
            OP_SUB:   side_next.res = a - b;
            OP_MUL:   side_next.res = prod;
            OP_AND:   side_next.res = a & b;
            OP_OR:    side_next.res = a | b;
            OP_XOR:   side_next.res = a ^ b;
            OP_NOT:   side_next.res = ~a;
            OP_NEG:   side_next.res = ~a + 32'd1;
            OP_NINES: side_next.res = nines;
            OP_TENS:  side_next.res = nines + 32'd1;
            OP_SHL:   side_next.res = a << sh;
            OP_SHR:   side_next.res = $unsigned($signed(a) >>> sh);
            default:  side_next.res = '0;
        endcase
        div_next.rem = '0;
        div_next.dvd = a[DataW-1] ? (~a + 32'd1) : a;
        div_next.dvs = b[DataW-1] ? (~b + 32'd1) : b;
    end

    // Hold on stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= side_next;
            div_reg  <= div_next;
        end
    end

endmodule

FILE: hw/rtl/ialu_div_stage.sv
module ialu_div_stage
    import ialu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       in_valid,
    input  ialu_side_t in_side,
    input  ialu_div_t  in_div,
    output logic       valid_reg,
    output ialu_side_t side_reg,
    output ialu_div_t  div_reg
);

    logic [DataW:0] shifted;
    logic [DataW:0] diff;
    logic           ge;
    ialu_div_t      div_next;

    // One restoring step: bring down a dividend bit, try the subtract
    always_comb
    begin
        shifted      = {in_div.rem, in_div.dvd[DataW-1]};
        diff         = shifted - {1'b0, in_div.dvs};
        ge           = !diff[DataW];
        div_next.rem = ge ? diff[DataW-1:0] : shifted[DataW-1:0];
        div_next.dvd = {in_div.dvd[DataW-2:0], ge};
        div_next.dvs = in_div.dvs;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= in_side;
            div_reg  <= div_next;
        end
    end

endmodule

FILE: hw/rtl/integer_alu_with_decimal_complement.sv
// 32-bit signed integer ALU with decimal nines and tens complement.
// Input stream: s_axis_tuser carries the opcode, s_axis_tdata the operands
// and shift amount. Output stream: m_axis_tdata carries the result and
// m_axis_tuser the divide-by-zero flag. One result per input transaction,
// in order.
// Path: one decode stage, one stage per quotient bit of the restoring
// divider, one output register. Every opcode takes the same path.
// Throughput: one transaction per cycle while the output is not stalled;
// the divider is fully unrolled into 32 registered steps, so a new item
// enters each cycle that the pipeline advances.
// Stall: while the output holds a result that is not taken, the whole
// pipeline freezes and s_axis_tready drops; nothing is lost or repeated.
// Reset: rst_n clears every stage valid bit; the block accepts a
// transaction in the first cycle after reset is released.
module integer_alu_with_decimal_complement
    import ialu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] operand_a, [63:32] operand_b, [68:64] shift_amount, [71:69] zero
    input  logic [71:0] s_axis_tdata,
    // [3:0] req_type
    input  logic [3:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] result
    output logic [31:0] m_axis_tdata,
    // [0] div_by_zero
    output logic [0:0]  m_axis_tuser
);

    localparam int Steps = DataW;

    logic             en;
    logic             v_w    [0:Steps];
    ialu_side_t       side_w [0:Steps];
    ialu_div_t        div_w  [0:Steps];
    logic             out_valid_reg;
    logic [DataW-1:0] out_data_reg;
    logic             out_dz_reg;
    logic [DataW-1:0] res_next;
    logic [DataW-1:0] q_mag;
    logic [DataW-1:0] r_mag;

    // Advance all stages when the output slot is free or being taken
    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    ialu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .op        (s_axis_tuser),
        .a         (s_axis_tdata[31:0]),
        .b         (s_axis_tdata[63:32]),
        .sh        (s_axis_tdata[68:64]),
        .valid_reg (v_w[0]),
        .side_reg  (side_w[0]),
        .div_reg   (div_w[0])
    );

    for (genvar i = 0; i < Steps; i++)
    begin : g_div
        ialu_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (v_w[i]),
            .in_side   (side_w[i]),
            .in_div    (div_w[i]),
            .valid_reg (v_w[i+1]),
            .side_reg  (side_w[i+1]),
            .div_reg   (div_w[i+1])
        );
    end

    // Fix signs and pick the final result
    always_comb
    begin
        q_mag = div_w[Steps].dvd;
        r_mag = div_w[Steps].rem;
        if (side_w[Steps].dz)
        begin
            res_next = '0;
        end
        else if (side_w[Steps].op == OP_DIV)
        begin
            res_next = side_w[Steps].neg_q ? (~q_mag + 32'd1) : q_mag;
        end
        else if (side_w[Steps].op == OP_MOD)
        begin
            res_next = side_w[Steps].neg_r ? (~r_mag + 32'd1) : r_mag;
        end
        else
        begin
            res_next = side_w[Steps].res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= v_w[Steps];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= res_next;
            out_dz_reg   <= side_w[Steps].dz;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_dz_reg;

`ifndef ASSERT_OFF
    // A zero divisor always yields a zero result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("div_by_zero with nonzero result");

    // A stalled pipeline keeps its last divider stage unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |=> $stable(v_w[Steps]) && $stable(div_w[Steps]))
        else $error("divider stage moved during stall");

    // The flag only comes from divide or remainder
    assert property (@(posedge clk) disable iff (!rst_n)
        v_w[Steps] && side_w[Steps].dz |->
            side_w[Steps].op == OP_DIV || side_w[Steps].op == OP_MOD)
        else $error("div_by_zero on non-divide opcode");
`endif

endmodule
